FILE: rtl/dtsw_pkg.sv
// ----------------------------------------------------------------------------
// dtsw_pkg
// Shared widths, operation codes, calendar constants and helper functions
// for the date/time setter with weekday.
// ----------------------------------------------------------------------------
package dtsw_pkg;

	// field widths
	localparam int OP_W    = 4;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int LEN_W   = 5;
	localparam int WDAY_W  = 3;
	localparam int ADD_W   = 6;

	// calendar limits
	localparam int MAX_YEAR_DEF = 9999;
	localparam logic [YEAR_W-1:0]  GREG_START_YEAR = 14'd1732;
	localparam logic [YEAR_W-1:0]  REFORM_YEAR     = 14'd1752;
	localparam logic [MONTH_W-1:0] REFORM_MONTH    = 4'd9;
	localparam logic [DAY_W-1:0]   REFORM_DAY      = 5'd2;
	// eleven skipped days, taken modulo seven (-11 = 3 mod 7)
	localparam logic [ADD_W-1:0]   REFORM_SKIP_MOD7 = 6'd3;
	localparam logic [ADD_W-1:0]   EPOCH_OFFSET     = 6'd4;

	localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
	localparam logic [HOUR_W-1:0]  HOUR_LAST   = 5'd23;
	localparam logic [MIN_W-1:0]   MIN_LAST    = 6'd59;
	localparam logic [SEC_W-1:0]   SEC_LAST    = 6'd59;

	// reset date
	localparam logic [YEAR_W-1:0] RESET_YEAR = 14'd2000;

	// operation codes; unlisted codes behave as a query
	typedef enum logic [OP_W-1:0] {
		OP_QUERY    = 4'd0,
		OP_LOAD     = 4'd1,
		OP_SEC_UP   = 4'd2,
		OP_SEC_DN   = 4'd3,
		OP_MIN_UP   = 4'd4,
		OP_MIN_DN   = 4'd5,
		OP_HOUR_UP  = 4'd6,
		OP_HOUR_DN  = 4'd7,
		OP_DAY_UP   = 4'd8,
		OP_DAY_DN   = 4'd9,
		OP_MONTH_UP = 4'd10,
		OP_MONTH_DN = 4'd11,
		OP_YEAR_UP  = 4'd12,
		OP_YEAR_DN  = 4'd13
	} op_t;

	// year walker control
	typedef struct packed {
		logic start;
		logic step;
	} walk_ctrl_t;

	// days in month m, given the leap flag of its year
	function automatic logic [LEN_W-1:0] month_len(input logic leap,
			input logic [MONTH_W-1:0] m);
		logic [LEN_W-1:0] n;
		begin
			unique case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
				4'd2: n = leap ? 5'd29 : 5'd28;
				default: n = '0;
			endcase
			return n;
		end
	endfunction

	// v mod 7 for a 6-bit value: quotient by reciprocal 37/256, exact below 85
	function automatic logic [2:0] mod7(input logic [ADD_W-1:0] v);
		logic [11:0] prod;
		logic [3:0]  q;
		logic [ADD_W-1:0] q7;
		logic [ADD_W-1:0] r;
		begin
			prod = {6'd0, v} * 12'd37;
			q    = prod[11:8];
			q7   = ADD_W'({2'd0, q} * 6'd7);
			r    = v - q7;
			return r[2:0];
		end
	endfunction

endpackage

FILE: rtl/dtsw_req_if.sv
// ----------------------------------------------------------------------------
// dtsw_req_if
// Request channel: operation code and the fields taken on a load.
// ----------------------------------------------------------------------------
interface dtsw_req_if;
	logic                          valid;
	logic                          ready;
	logic [dtsw_pkg::OP_W-1:0]     operation;
	logic [dtsw_pkg::YEAR_W-1:0]   load_year;
	logic [dtsw_pkg::MONTH_W-1:0]  load_month;
	logic [dtsw_pkg::DAY_W-1:0]    load_day;
	logic [dtsw_pkg::HOUR_W-1:0]   load_hours;
	logic [dtsw_pkg::MIN_W-1:0]    load_minutes;
	logic [dtsw_pkg::SEC_W-1:0]    load_seconds;

	modport source (
		output valid, operation, load_year, load_month, load_day,
		       load_hours, load_minutes, load_seconds,
		input  ready
	);
	modport sink (
		input  valid, operation, load_year, load_month, load_day,
		       load_hours, load_minutes, load_seconds,
		output ready
	);
endinterface

FILE: rtl/dtsw_rsp_if.sv
// ----------------------------------------------------------------------------
// dtsw_rsp_if
// Result channel: current date, time, month length and weekday.
// ----------------------------------------------------------------------------
interface dtsw_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [dtsw_pkg::YEAR_W-1:0]   cur_year;
	logic [dtsw_pkg::MONTH_W-1:0]  cur_month;
	logic [dtsw_pkg::DAY_W-1:0]    cur_day;
	logic [dtsw_pkg::HOUR_W-1:0]   cur_hours;
	logic [dtsw_pkg::MIN_W-1:0]    cur_minutes;
	logic [dtsw_pkg::SEC_W-1:0]    cur_seconds;
	logic [dtsw_pkg::LEN_W-1:0]    month_length;
	logic [dtsw_pkg::WDAY_W-1:0]   weekday;

	modport source (
		output valid, cur_year, cur_month, cur_day, cur_hours, cur_minutes,
		       cur_seconds, month_length, weekday,
		input  ready
	);
	modport sink (
		input  valid, cur_year, cur_month, cur_day, cur_hours, cur_minutes,
		       cur_seconds, month_length, weekday,
		output ready
	);
endinterface

FILE: rtl/dtsw_mod7_unit.sv
// ----------------------------------------------------------------------------
// dtsw_mod7_unit
// Shared modulo-7 accumulator: acc <= (acc + addend mod 7) mod 7.
// ----------------------------------------------------------------------------
module dtsw_mod7_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clear,
	input  logic                         en,
	input  logic [dtsw_pkg::ADD_W-1:0]   addend,
	output logic [dtsw_pkg::WDAY_W-1:0]  acc
);

	logic [dtsw_pkg::WDAY_W-1:0] acc_q;
	logic [3:0]                  sum;
	logic [dtsw_pkg::WDAY_W-1:0] nxt;

	// reduce addend, add, one compare and subtract
	always_comb begin
		sum = {1'b0, acc_q} + {1'b0, dtsw_pkg::mod7(addend)};
		nxt = (sum >= 4'd7) ? 3'(sum - 4'd7) : sum[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
		end else if (en) begin
			acc_q <= nxt;
		end
	end

	assign acc = acc_q;

endmodule

FILE: rtl/dtsw_year_walker.sv
// ----------------------------------------------------------------------------
// dtsw_year_walker
// Year index counter from year 1 with running mod 4/100/400 residues,
// giving the leap flag of the year it currently points at.
// ----------------------------------------------------------------------------
module dtsw_year_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dtsw_pkg::walk_ctrl_t         ctrl,
	output logic [dtsw_pkg::YEAR_W-1:0]  year_idx,
	output logic                         leap
);

	logic [dtsw_pkg::YEAR_W-1:0] idx_q;
	logic [1:0]                  m4_q;
	logic [6:0]                  m100_q;
	logic [8:0]                  m400_q;

	// counters restart at year 1 and advance one year per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 14'd1;
			m4_q   <= 2'd1;
			m100_q <= 7'd1;
			m400_q <= 9'd1;
		end else if (ctrl.start) begin
			idx_q  <= 14'd1;
			m4_q   <= 2'd1;
			m100_q <= 7'd1;
			m400_q <= 9'd1;
		end else if (ctrl.step) begin
			idx_q  <= idx_q + 14'd1;
			m4_q   <= m4_q + 2'd1;
			m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
			m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
		end
	end

	// julian rule before the gregorian start year, gregorian after
	always_comb begin
		if (idx_q < dtsw_pkg::GREG_START_YEAR) begin
			leap = (m4_q == 2'd0);
		end else begin
			leap = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
		end
	end

	assign year_idx = idx_q;

endmodule

FILE: rtl/date_time_setter_with_weekday_core.sv
// Sequence: an accepted request runs the year walk (one year per cycle), a day step and the
// month walk (one month per cycle) through the shared modulo-7 accumulator, then a final
// weekday add, and the result waits in the done state for the result register.
// Requests: a new request is taken only once the last result is loaded; ready is low
// while a request is worked and while a finished result waits for the result register.
// Reset: asynchronous, active low; date 2000-01-01, time 00:00:00, no result.
// ----------------------------------------------------------------------------
// date_time_setter_with_weekday_core
// Settable date and time with step/wrap controls, month length and weekday.
// ----------------------------------------------------------------------------
module date_time_setter_with_weekday_core #(
	parameter int MAX_YEAR = dtsw_pkg::MAX_YEAR_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	dtsw_req_if.sink       request,
	dtsw_rsp_if.source     result
);

	localparam logic [dtsw_pkg::YEAR_W-1:0] MaxYear = dtsw_pkg::YEAR_W'(MAX_YEAR);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_YEARS  = 6'b000010,
		ST_DAY    = 6'b000100,
		ST_MONTHS = 6'b001000,
		ST_FINAL  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;

	logic [dtsw_pkg::YEAR_W-1:0]  year_q;
	logic [dtsw_pkg::MONTH_W-1:0] month_q;
	logic [dtsw_pkg::DAY_W-1:0]   day_q;
	logic [dtsw_pkg::HOUR_W-1:0]  hours_q;
	logic [dtsw_pkg::MIN_W-1:0]   minutes_q;
	logic [dtsw_pkg::SEC_W-1:0]   seconds_q;
	dtsw_pkg::op_t                op_q;
	logic [dtsw_pkg::LEN_W-1:0]   len_q;
	logic [dtsw_pkg::MONTH_W-1:0] month_idx_q;

	logic                         out_valid_q;
	logic [dtsw_pkg::YEAR_W-1:0]  out_year_q;
	logic [dtsw_pkg::MONTH_W-1:0] out_month_q;
	logic [dtsw_pkg::DAY_W-1:0]   out_day_q;
	logic [dtsw_pkg::HOUR_W-1:0]  out_hours_q;
	logic [dtsw_pkg::MIN_W-1:0]   out_minutes_q;
	logic [dtsw_pkg::SEC_W-1:0]   out_seconds_q;
	logic [dtsw_pkg::LEN_W-1:0]   out_len_q;
	logic [dtsw_pkg::WDAY_W-1:0]  out_wday_q;

	logic                         req_fire;
	logic                         out_load;
	dtsw_pkg::op_t                req_op;
	dtsw_pkg::walk_ctrl_t         walk_ctrl;
	logic [dtsw_pkg::YEAR_W-1:0]  walk_year;
	logic                         walk_leap;
	logic                         acc_clear;
	logic                         acc_en;
	logic [dtsw_pkg::ADD_W-1:0]   acc_addend;
	logic [dtsw_pkg::WDAY_W-1:0]  acc_val;
	logic [dtsw_pkg::LEN_W-1:0]   cur_len;
	logic                         after_reform;

	// saturated load fields
	logic [dtsw_pkg::YEAR_W-1:0]  ld_year;
	logic [dtsw_pkg::MONTH_W-1:0] ld_month;
	logic [dtsw_pkg::DAY_W-1:0]   ld_day;
	logic [dtsw_pkg::HOUR_W-1:0]  ld_hours;
	logic [dtsw_pkg::MIN_W-1:0]   ld_minutes;
	logic [dtsw_pkg::SEC_W-1:0]   ld_seconds;

	assign request.ready = (state_q == ST_IDLE);
	assign req_fire      = request.valid && request.ready;
	assign req_op        = dtsw_pkg::op_t'(request.operation);
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	// load saturation
	always_comb begin
		if (request.load_year == '0) begin
			ld_year = 14'd1;
		end else if (request.load_year > MaxYear) begin
			ld_year = MaxYear;
		end else begin
			ld_year = request.load_year;
		end
		if (request.load_month == '0) begin
			ld_month = dtsw_pkg::MONTH_FIRST;
		end else if (request.load_month > dtsw_pkg::MONTH_LAST) begin
			ld_month = dtsw_pkg::MONTH_LAST;
		end else begin
			ld_month = request.load_month;
		end
		ld_day     = (request.load_day == '0) ? dtsw_pkg::DAY_FIRST : request.load_day;
		ld_hours   = (request.load_hours > dtsw_pkg::HOUR_LAST) ?
			dtsw_pkg::HOUR_LAST : request.load_hours;
		ld_minutes = (request.load_minutes > dtsw_pkg::MIN_LAST) ?
			dtsw_pkg::MIN_LAST : request.load_minutes;
		ld_seconds = (request.load_seconds > dtsw_pkg::SEC_LAST) ?
			dtsw_pkg::SEC_LAST : request.load_seconds;
	end

	// month length of the stored date, valid once the walk reached year_q
	assign cur_len = dtsw_pkg::month_len(walk_leap, month_q);

	// dates after the calendar reform lose eleven days
	assign after_reform = (year_q > dtsw_pkg::REFORM_YEAR) ||
		((year_q == dtsw_pkg::REFORM_YEAR) && (month_q > dtsw_pkg::REFORM_MONTH)) ||
		((year_q == dtsw_pkg::REFORM_YEAR) && (month_q == dtsw_pkg::REFORM_MONTH) &&
		 (day_q > dtsw_pkg::REFORM_DAY));

	// sequencer drive of the shared accumulator and the year walker
	always_comb begin
		walk_ctrl  = '0;
		acc_clear  = 1'b0;
		acc_en     = 1'b0;
		acc_addend = '0;
		unique case (state_q)
			ST_IDLE: begin
				walk_ctrl.start = req_fire;
				acc_clear       = req_fire;
			end
			ST_YEARS: begin
				// each full year adds 365 + leap days, 365 = 1 mod 7
				if (walk_year != year_q) begin
					walk_ctrl.step = 1'b1;
					acc_en         = 1'b1;
					acc_addend     = {5'd0, walk_leap} + 6'd1;
				end
			end
			ST_MONTHS: begin
				if (month_idx_q != month_q) begin
					acc_en     = 1'b1;
					acc_addend = {1'b0, dtsw_pkg::month_len(walk_leap, month_idx_q)};
				end
			end
			ST_FINAL: begin
				acc_en     = 1'b1;
				acc_addend = {1'b0, day_q} + dtsw_pkg::EPOCH_OFFSET +
					(after_reform ? dtsw_pkg::REFORM_SKIP_MOD7 : 6'd0);
			end
			ST_DAY, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	dtsw_year_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (walk_ctrl),
		.year_idx (walk_year),
		.leap     (walk_leap)
	);

	dtsw_mod7_unit u_mod7 (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (acc_clear),
		.en     (acc_en),
		.addend (acc_addend),
		.acc    (acc_val)
	);

	// sequencer and date/time state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			year_q      <= dtsw_pkg::RESET_YEAR;
			month_q     <= dtsw_pkg::MONTH_FIRST;
			day_q       <= dtsw_pkg::DAY_FIRST;
			hours_q     <= '0;
			minutes_q   <= '0;
			seconds_q   <= '0;
			op_q        <= dtsw_pkg::OP_QUERY;
			month_idx_q <= dtsw_pkg::MONTH_FIRST;
			len_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						op_q    <= req_op;
						state_q <= ST_YEARS;
						// field steps that do not need the month length
						unique case (req_op)
							dtsw_pkg::OP_LOAD: begin
								year_q    <= ld_year;
								month_q   <= ld_month;
								day_q     <= ld_day;
								hours_q   <= ld_hours;
								minutes_q <= ld_minutes;
								seconds_q <= ld_seconds;
							end
							dtsw_pkg::OP_SEC_UP:
								seconds_q <= (seconds_q >= dtsw_pkg::SEC_LAST) ?
									'0 : seconds_q + 6'd1;
							dtsw_pkg::OP_SEC_DN:
								seconds_q <= (seconds_q == '0) ?
									dtsw_pkg::SEC_LAST : seconds_q - 6'd1;
							dtsw_pkg::OP_MIN_UP:
								minutes_q <= (minutes_q >= dtsw_pkg::MIN_LAST) ?
									'0 : minutes_q + 6'd1;
							dtsw_pkg::OP_MIN_DN:
								minutes_q <= (minutes_q == '0) ?
									dtsw_pkg::MIN_LAST : minutes_q - 6'd1;
							dtsw_pkg::OP_HOUR_UP:
								hours_q <= (hours_q >= dtsw_pkg::HOUR_LAST) ?
									'0 : hours_q + 5'd1;
							dtsw_pkg::OP_HOUR_DN:
								hours_q <= (hours_q == '0) ?
									dtsw_pkg::HOUR_LAST : hours_q - 5'd1;
							dtsw_pkg::OP_MONTH_UP:
								month_q <= (month_q >= dtsw_pkg::MONTH_LAST) ?
									dtsw_pkg::MONTH_FIRST : month_q + 4'd1;
							dtsw_pkg::OP_MONTH_DN:
								month_q <= (month_q <= dtsw_pkg::MONTH_FIRST) ?
									dtsw_pkg::MONTH_LAST : month_q - 4'd1;
							dtsw_pkg::OP_YEAR_UP:
								if (year_q < MaxYear) year_q <= year_q + 14'd1;
							dtsw_pkg::OP_YEAR_DN:
								if (year_q > 14'd1) year_q <= year_q - 14'd1;
							default: begin
							end
						endcase
					end
				end
				ST_YEARS: begin
					if (walk_year == year_q) begin
						state_q <= ST_DAY;
					end
				end
				ST_DAY: begin
					// day steps and clamping use the new month length
					len_q       <= cur_len;
					month_idx_q <= dtsw_pkg::MONTH_FIRST;
					state_q     <= ST_MONTHS;
					unique case (op_q)
						dtsw_pkg::OP_DAY_UP:
							day_q <= (day_q >= cur_len) ? dtsw_pkg::DAY_FIRST : day_q + 5'd1;
						dtsw_pkg::OP_DAY_DN:
							day_q <= (day_q <= dtsw_pkg::DAY_FIRST) ? cur_len : day_q - 5'd1;
						dtsw_pkg::OP_LOAD, dtsw_pkg::OP_MONTH_UP, dtsw_pkg::OP_MONTH_DN,
						dtsw_pkg::OP_YEAR_UP, dtsw_pkg::OP_YEAR_DN:
							if (day_q > cur_len) day_q <= cur_len;
						default: begin
						end
					endcase
				end
				ST_MONTHS: begin
					if (month_idx_q == month_q) begin
						state_q <= ST_FINAL;
					end else begin
						month_idx_q <= month_idx_q + 4'd1;
					end
				end
				ST_FINAL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_year_q    <= year_q;
			out_month_q   <= month_q;
			out_day_q     <= day_q;
			out_hours_q   <= hours_q;
			out_minutes_q <= minutes_q;
			out_seconds_q <= seconds_q;
			out_len_q     <= len_q;
			out_wday_q    <= acc_val;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.cur_year     = out_year_q;
	assign result.cur_month    = out_month_q;
	assign result.cur_day      = out_day_q;
	assign result.cur_hours    = out_hours_q;
	assign result.cur_minutes  = out_minutes_q;
	assign result.cur_seconds  = out_seconds_q;
	assign result.month_length = out_len_q;
	assign result.weekday      = out_wday_q;

endmodule

FILE: rtl/dtsw_checker.sv
// ----------------------------------------------------------------------------
// dtsw_checker
// Port-level checks on the date/time setter, bound to the top level.
// ----------------------------------------------------------------------------
module dtsw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [dtsw_pkg::MONTH_W-1:0]  cur_month,
	input logic [dtsw_pkg::DAY_W-1:0]    cur_day,
	input logic [dtsw_pkg::LEN_W-1:0]    month_length,
	input logic [dtsw_pkg::WDAY_W-1:0]   weekday
);

	// a stalled result holds its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(cur_day) &&
		$stable(weekday) && $stable(month_length))
		else $error("result changed while stalled");

	// the block is busy right after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// the day lies within the reported month length
	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cur_day >= dtsw_pkg::DAY_FIRST && cur_day <= month_length)
		else $error("day outside month");

	// month length, month and weekday lie in their ranges
	a_len_wday: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> weekday <= 3'd6 && month_length >= 5'd28 &&
		month_length <= 5'd31 && cur_month >= dtsw_pkg::MONTH_FIRST &&
		cur_month <= dtsw_pkg::MONTH_LAST)
		else $error("month length, month or weekday out of range");

endmodule

bind date_time_setter_with_weekday_core dtsw_checker u_dtsw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (request.valid),
	.req_ready    (request.ready),
	.rsp_valid    (result.valid),
	.rsp_ready    (result.ready),
	.cur_month    (result.cur_month),
	.cur_day      (result.cur_day),
	.month_length (result.month_length),
	.weekday      (result.weekday)
);

FILE: verif/date_time_setter_with_weekday_core_tb.sv
// ----------------------------------------------------------------------------
// date_time_setter_with_weekday_core_tb
// Drives set/step/query requests into the date/time core and checks every
// result field by field against a calendar model kept in the bench: wrap of
// each field, day clamping, leap rules on both sides of 1732, the 1752
// weekday shift and saturation of out-of-range loads. A directed table runs
// first, then random episodes with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module date_time_setter_with_weekday_core_tb;
	import dtsw_pkg::*;

	localparam int MAX_YEAR      = MAX_YEAR_DEF;
	localparam int RANDOM_ITEMS  = 75;
	localparam int IDLE_LIMIT    = 50000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int TABLE_ROWS    = 25;

	// codes outside the enum; the core treats them as a query
	localparam logic [OP_W-1:0] OP_SPARE_14 = 4'd14;
	localparam logic [OP_W-1:0] OP_SPARE_15 = 4'd15;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [YEAR_W-1:0]  load_year;
		logic [MONTH_W-1:0] load_month;
		logic [DAY_W-1:0]   load_day;
		logic [HOUR_W-1:0]  load_hours;
		logic [MIN_W-1:0]   load_minutes;
		logic [SEC_W-1:0]   load_seconds;
	} date_req_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  cur_year;
		logic [MONTH_W-1:0] cur_month;
		logic [DAY_W-1:0]   cur_day;
		logic [HOUR_W-1:0]  cur_hours;
		logic [MIN_W-1:0]   cur_minutes;
		logic [SEC_W-1:0]   cur_seconds;
		logic [LEN_W-1:0]   month_length;
		logic [WDAY_W-1:0]  weekday;
	} date_rsp_t;

	// one table row: request, then the typed date/time when has_typed is set
	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [YEAR_W-1:0]  load_year;
		logic [MONTH_W-1:0] load_month;
		logic [DAY_W-1:0]   load_day;
		logic [HOUR_W-1:0]  load_hours;
		logic [MIN_W-1:0]   load_minutes;
		logic [SEC_W-1:0]   load_seconds;
		logic               has_typed;
		logic [YEAR_W-1:0]  t_year;
		logic [MONTH_W-1:0] t_month;
		logic [DAY_W-1:0]   t_day;
		logic [HOUR_W-1:0]  t_hours;
		logic [MIN_W-1:0]   t_minutes;
		logic [SEC_W-1:0]   t_seconds;
		logic [LEN_W-1:0]   t_length;
	} table_row_t;

	table_row_t directed_table [TABLE_ROWS] = '{
		// wraps of every field but the year from the reset date
		'{OP_QUERY,    0, 0, 0, 0, 0, 0,     1, 2000, 1, 1, 0, 0, 0, 31},
		'{OP_SEC_DN,   0, 0, 0, 0, 0, 0,     1, 2000, 1, 1, 0, 0, 59, 31},
		'{OP_MIN_DN,   0, 0, 0, 0, 0, 0,     1, 2000, 1, 1, 0, 59, 59, 31},
		'{OP_HOUR_DN,  0, 0, 0, 0, 0, 0,     1, 2000, 1, 1, 23, 59, 59, 31},
		'{OP_SEC_UP,   0, 0, 0, 0, 0, 0,     1, 2000, 1, 1, 23, 59, 0, 31},
		'{OP_MIN_UP,   0, 0, 0, 0, 0, 0,     1, 2000, 1, 1, 23, 0, 0, 31},
		'{OP_HOUR_UP,  0, 0, 0, 0, 0, 0,     1, 2000, 1, 1, 0, 0, 0, 31},
		'{OP_DAY_DN,   0, 0, 0, 0, 0, 0,     1, 2000, 1, 31, 0, 0, 0, 31},
		'{OP_DAY_UP,   0, 0, 0, 0, 0, 0,     1, 2000, 1, 1, 0, 0, 0, 31},
		'{OP_MONTH_DN, 0, 0, 0, 0, 0, 0,     1, 2000, 12, 1, 0, 0, 0, 31},
		'{OP_MONTH_UP, 0, 0, 0, 0, 0, 0,     1, 2000, 1, 1, 0, 0, 0, 31},
		// load saturation at both ends and year saturation
		'{OP_LOAD, 16383, 15, 31, 31, 63, 63, 1, 9999, 12, 31, 23, 59, 59, 31},
		'{OP_YEAR_UP,  0, 0, 0, 0, 0, 0,     1, 9999, 12, 31, 23, 59, 59, 31},
		'{OP_LOAD,     0, 0, 0, 0, 0, 0,     1, 1, 1, 1, 0, 0, 0, 31},
		'{OP_YEAR_DN,  0, 0, 0, 0, 0, 0,     1, 1, 1, 1, 0, 0, 0, 31},
		// day clamping after month and year steps
		'{OP_LOAD, 2000, 1, 31, 12, 30, 45,  1, 2000, 1, 31, 12, 30, 45, 31},
		'{OP_MONTH_UP, 0, 0, 0, 0, 0, 0,     1, 2000, 2, 29, 12, 30, 45, 29},
		'{OP_YEAR_UP,  0, 0, 0, 0, 0, 0,     1, 2001, 2, 28, 12, 30, 45, 28},
		// julian century leap year, gregorian century common year
		'{OP_LOAD, 1700, 2, 29, 1, 2, 3,     1, 1700, 2, 29, 1, 2, 3, 29},
		'{OP_LOAD, 1900, 2, 29, 4, 5, 6,     1, 1900, 2, 28, 4, 5, 6, 28},
		// last day before the weekday shift, then across it
		'{OP_LOAD, 1752, 9, 2, 7, 8, 9,      0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_DAY_UP,   0, 0, 0, 0, 0, 0,     0, 0, 0, 0, 0, 0, 0, 0},
		// spare codes with junk payload
		'{OP_SPARE_14, 16383, 15, 31, 31, 63, 63, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SPARE_15, 5461, 10, 21, 10, 42, 21,  0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_LOAD, 2000, 4, 31, 0, 0, 0,     1, 2000, 4, 30, 0, 0, 0, 30}
	};

	logic clk;
	logic arst_n;

	dtsw_req_if req_if ();
	dtsw_rsp_if rsp_if ();

	date_time_setter_with_weekday_core #(
		.MAX_YEAR (MAX_YEAR)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_if),
		.result  (rsp_if)
	);

	// calendar state of the bench model
	int cal_year;
	int cal_month;
	int cal_day;
	int cal_hours;
	int cal_minutes;
	int cal_seconds;

	date_rsp_t expected_dates [$];
	int        error_count;
	int        idle_cycles;
	int        burst_left;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// calendar model
	function automatic int is_leap(input int y);
		if (y < 1732)
			return (y % 4 == 0) ? 1 : 0;
		return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 1 : 0;
	endfunction

	function automatic int days_in_month(input int y, input int m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return 28 + is_leap(y);
			default:               return 0;
		endcase
	endfunction

	function automatic logic [WDAY_W-1:0] weekday_index(input int y, input int m, input int d);
		int total;
		int i;
		total = 0;
		for (i = 1; i < y; i++)
			total += 365 + is_leap(i);
		for (i = 1; i < m; i++)
			total += days_in_month(y, i);
		total += d + 4;
		// eleven days dropped after 2 sep 1752
		if (y > 1752 || (y == 1752 && (m > 9 || (m == 9 && d > 2))))
			total -= 11;
		return WDAY_W'(total % 7);
	endfunction

	// apply one request to the model and return the date it should report
	function automatic date_rsp_t advance_calendar(input date_req_t r);
		date_rsp_t p;
		int        n;
		case (r.operation)
			OP_LOAD: begin
				cal_year    = r.load_year;
				cal_month   = r.load_month;
				cal_day     = r.load_day;
				cal_hours   = r.load_hours;
				cal_minutes = r.load_minutes;
				cal_seconds = r.load_seconds;
				if (cal_year < 1) cal_year = 1;
				if (cal_year > MAX_YEAR) cal_year = MAX_YEAR;
				if (cal_month < 1) cal_month = 1;
				if (cal_month > 12) cal_month = 12;
				if (cal_day < 1) cal_day = 1;
				if (cal_hours > 23) cal_hours = 23;
				if (cal_minutes > 59) cal_minutes = 59;
				if (cal_seconds > 59) cal_seconds = 59;
			end
			OP_SEC_UP:   cal_seconds = (cal_seconds + 1) % 60;
			OP_SEC_DN:   cal_seconds = (cal_seconds == 0) ? 59 : cal_seconds - 1;
			OP_MIN_UP:   cal_minutes = (cal_minutes + 1) % 60;
			OP_MIN_DN:   cal_minutes = (cal_minutes == 0) ? 59 : cal_minutes - 1;
			OP_HOUR_UP:  cal_hours = (cal_hours + 1) % 24;
			OP_HOUR_DN:  cal_hours = (cal_hours == 0) ? 23 : cal_hours - 1;
			OP_DAY_UP: begin
				n = days_in_month(cal_year, cal_month);
				cal_day = (cal_day + 1 > n) ? 1 : cal_day + 1;
			end
			OP_DAY_DN: begin
				n = days_in_month(cal_year, cal_month);
				cal_day = (cal_day <= 1) ? n : cal_day - 1;
			end
			OP_MONTH_UP: cal_month = (cal_month >= 12) ? 1 : cal_month + 1;
			OP_MONTH_DN: cal_month = (cal_month <= 1) ? 12 : cal_month - 1;
			OP_YEAR_UP:  if (cal_year < MAX_YEAR) cal_year++;
			OP_YEAR_DN:  if (cal_year > 1) cal_year--;
			default: ;
		endcase
		// the day is clamped to the month after every request; this only changes a day beyond the month
		n = days_in_month(cal_year, cal_month);
		if (cal_day > n)
			cal_day = n;
		p.cur_year     = YEAR_W'(cal_year);
		p.cur_month    = MONTH_W'(cal_month);
		p.cur_day      = DAY_W'(cal_day);
		p.cur_hours    = HOUR_W'(cal_hours);
		p.cur_minutes  = MIN_W'(cal_minutes);
		p.cur_seconds  = SEC_W'(cal_seconds);
		p.month_length = LEN_W'(n);
		p.weekday      = weekday_index(cal_year, cal_month, cal_day);
		return p;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		error_count++;
	endtask

	// drive one request in bursts, record the expected date on accept
	task automatic send_request(input date_req_t r, input bit has_typed, input date_rsp_t typed);
		int        gap;
		date_rsp_t want;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 6);
		end
		req_if.valid        <= 1'b1;
		req_if.operation    <= r.operation;
		req_if.load_year    <= r.load_year;
		req_if.load_month   <= r.load_month;
		req_if.load_day     <= r.load_day;
		req_if.load_hours   <= r.load_hours;
		req_if.load_minutes <= r.load_minutes;
		req_if.load_seconds <= r.load_seconds;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		want = advance_calendar(r);
		if (has_typed) begin
			typed.weekday = want.weekday;
			want = typed;
		end
		expected_dates.insert(expected_dates.size(), want);
		burst_left--;
		@(negedge clk);
	endtask

	// hold off until every outstanding request has been answered
	task automatic wait_for_drain();
		req_if.valid <= 1'b0;
		while (expected_dates.size() != 0)
			@(negedge clk);
	endtask

	// random load: mostly sane fields, some out-of-range values
	function automatic date_req_t random_load();
		date_req_t r;
		r.operation = OP_LOAD;
		case ($urandom_range(0, 19))
			0:       r.load_year = YEAR_W'($urandom_range(0, 3));
			1:       r.load_year = YEAR_W'($urandom_range(9990, 16383));
			2:       r.load_year = YEAR_W'($urandom_range(0, 16383));
			3, 4, 5: r.load_year = YEAR_W'($urandom_range(1728, 1760));
			default: r.load_year = YEAR_W'($urandom_range(1, 2100));
		endcase
		r.load_month   = MONTH_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 15)
			: $urandom_range(1, 12));
		r.load_day     = DAY_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
			: $urandom_range(1, 31));
		r.load_hours   = HOUR_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 31)
			: $urandom_range(0, 23));
		r.load_minutes = MIN_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 63)
			: $urandom_range(0, 59));
		r.load_seconds = SEC_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 63)
			: $urandom_range(0, 59));
		return r;
	endfunction

	// stimulus
	initial begin
		date_req_t  r;
		date_rsp_t  typed;
		table_row_t row;
		int         sent;
		int         run;
		int         pick;

		error_count         = 0;
		burst_left          = 0;
		arst_n              = 1'b0;
		req_if.valid        = 1'b0;
		req_if.operation    = '0;
		req_if.load_year    = '0;
		req_if.load_month   = '0;
		req_if.load_day     = '0;
		req_if.load_hours   = '0;
		req_if.load_minutes = '0;
		req_if.load_seconds = '0;
		cal_year            = RESET_YEAR;
		cal_month           = 1;
		cal_day             = 1;
		cal_hours           = 0;
		cal_minutes         = 0;
		cal_seconds         = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (directed_table[i]) begin
			row                = directed_table[i];
			r.operation        = row.operation;
			r.load_year        = row.load_year;
			r.load_month       = row.load_month;
			r.load_day         = row.load_day;
			r.load_hours       = row.load_hours;
			r.load_minutes     = row.load_minutes;
			r.load_seconds     = row.load_seconds;
			typed.cur_year     = row.t_year;
			typed.cur_month    = row.t_month;
			typed.cur_day      = row.t_day;
			typed.cur_hours    = row.t_hours;
			typed.cur_minutes  = row.t_minutes;
			typed.cur_seconds  = row.t_seconds;
			typed.month_length = row.t_length;
			typed.weekday      = '0;
			send_request(r, row.has_typed, typed);
		end
		wait_for_drain();

		// random episodes: a load, or a run of one step, query or spare op, with random payload
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				send_request(random_load(), 1'b0, typed);
				sent++;
			end else begin
				r = date_req_t'({YEAR_W'($urandom), 30'($urandom)});
				if (pick < 90)
					r.operation = OP_W'($urandom_range(OP_SEC_UP, OP_YEAR_DN));
				else
					case ($urandom_range(0, 2))
						0:       r.operation = OP_QUERY;
						1:       r.operation = OP_SPARE_14;
						default: r.operation = OP_SPARE_15;
					endcase
				run = $urandom_range(1, 6);
				while (run > 0 && sent < RANDOM_ITEMS) begin
					send_request(r, 1'b0, typed);
					r = date_req_t'({r.operation, YEAR_W'($urandom), 26'($urandom)});
					run--;
					sent++;
				end
			end
			if (sent == RANDOM_ITEMS / 2)
				wait_for_drain();
		end
		req_if.valid <= 1'b0;

		// drain, then watch for stray results
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[date_time_setter_with_weekday_core] OK");
		else
			$display("[date_time_setter_with_weekday_core] ERROR");
		$finish;
	end

	// result receiver with its own stall pattern
	initial begin
		logic [15:0] stall_pattern;
		int          pattern_age;
		rsp_if.ready  = 1'b0;
		stall_pattern = 16'hFFFF;
		pattern_age   = 0;
		forever begin
			@(negedge clk);
			if (pattern_age == 0) begin
				stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
					: (16'($urandom) | 16'h0101);
				pattern_age   = $urandom_range(16, 96);
			end
			rsp_if.ready  <= stall_pattern[0];
			stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
			pattern_age--;
		end
	end

	// result checker
	task automatic check_result();
		date_rsp_t got;
		date_rsp_t want;
		int        got_v [8];
		int        want_v [8];
		string     names [8];
		got.cur_year     = rsp_if.cur_year;
		got.cur_month    = rsp_if.cur_month;
		got.cur_day      = rsp_if.cur_day;
		got.cur_hours    = rsp_if.cur_hours;
		got.cur_minutes  = rsp_if.cur_minutes;
		got.cur_seconds  = rsp_if.cur_seconds;
		got.month_length = rsp_if.month_length;
		got.weekday      = rsp_if.weekday;
		if (expected_dates.size() == 0) begin
			report_mismatch("result with no request outstanding");
			return;
		end
		want = expected_dates.pop_front();
		if ($isunknown(got))
			report_mismatch("result carries unknown bits");
		names  = '{"cur_year", "cur_month", "cur_day", "cur_hours", "cur_minutes",
			"cur_seconds", "month_length", "weekday"};
		got_v  = '{got.cur_year, got.cur_month, got.cur_day, got.cur_hours,
			got.cur_minutes, got.cur_seconds, got.month_length, got.weekday};
		want_v = '{want.cur_year, want.cur_month, want.cur_day, want.cur_hours,
			want.cur_minutes, want.cur_seconds, want.month_length, want.weekday};
		foreach (names[i])
			if (got_v[i] != want_v[i])
				report_mismatch($sformatf("%s got %0d want %0d (date %0d-%0d-%0d)",
					names[i], got_v[i], want_v[i], want.cur_year, want.cur_month,
					want.cur_day));
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			check_result();
	end

	// watchdog on cycles with no request or result accepted
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		@(posedge clk);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("[date_time_setter_with_weekday_core] ERROR");
		$finish;
	end

endmodule
